// File: src/wip_pkg.sv
`default_nettype none

package wip_pkg;

   // field widths
   localparam int ZOOM_W     = 10;
   localparam int HDIV_W     = 8;
   localparam int MAP_W      = 13;
   localparam int OFS_W      = 16;
   localparam int COEF_W     = 16;
   localparam int COL_W      = 12;
   localparam int HGT_W      = 16;
   localparam int OUT_W      = 32;

   // projection constants
   localparam int SCREEN_W     = 1920;
   localparam int SCREEN_H     = 1080;
   localparam int FRAC_BITS    = 14;
   localparam int ISO_FRAC     = 14;
   localparam int ISO_COS30    = 14189;
   localparam int ISO_SIN30    = 8192;
   localparam int ISO_SIN30_SH = $clog2(ISO_SIN30);
   localparam int ISO_COEF_W   = 16;

   // internal widths
   localparam int COLZ_W    = COL_W + ZOOM_W;
   localparam int CEN_W     = MAP_W + ZOOM_W;
   localparam int ZPROD_W   = HGT_W + ZOOM_W + 1;
   localparam int DIV_SPLIT = ZOOM_W / 2;
   localparam int PROD_W    = OUT_W + COEF_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int ISO_W     = OUT_W + ISO_COEF_W;
   localparam int WIDE_W    = 64;

   // pipeline depth
   localparam int FRONT_LAT = 3;
   localparam int ROT_LAT   = 3;
   localparam int ISO_LAT   = 4;
   localparam int PIPE_LAT  = FRONT_LAT + 3 * ROT_LAT + ISO_LAT;

   // control register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_DIV  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_COLUMNS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_ROWS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLE   = 3'd7;

   typedef struct packed {
      logic        [ZOOM_W-1:0] zoom;
      logic        [HDIV_W-1:0] height_divisor;
      logic        [MAP_W-1:0]  map_columns;
      logic        [MAP_W-1:0]  map_rows;
      logic signed [OFS_W-1:0]  offset_x;
      logic signed [OFS_W-1:0]  offset_y;
      logic signed [COEF_W-1:0] cos_angle;
      logic signed [COEF_W-1:0] sin_angle;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      zoom:           ZOOM_W'(1),
      height_divisor: HDIV_W'(1),
      map_columns:    MAP_W'(1),
      map_rows:       MAP_W'(1),
      offset_x:       '0,
      offset_y:       '0,
      cos_angle:      COEF_W'(16384),
      sin_angle:      '0
   };

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
   } point_type;

   // arithmetic shift right with truncation toward zero, wrapped to OUT_W
   function automatic logic signed [OUT_W-1:0] trunc_frac(
      input logic signed [WIDE_W-1:0] v,
      input int unsigned              sh);
      logic signed [WIDE_W-1:0] bias;
      logic signed [WIDE_W-1:0] t;
      bias = v[WIDE_W-1] ? ((WIDE_W'(1) <<< sh) - WIDE_W'(1)) : '0;
      t    = (v + bias) >>> sh;
      return t[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/wip_front.sv
`default_nettype none

module wip_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic        [wip_pkg::COL_W-1:0] grid_col,
   input  logic        [wip_pkg::COL_W-1:0] grid_row,
   input  logic signed [wip_pkg::HGT_W-1:0] height,
   input  wip_pkg::cfg_type                 cfg,
   output logic                             out_valid,
   output wip_pkg::point_type               out_pt
);
   import wip_pkg::*;

   // stage 1: grid scaling, center products, upper quotient bits
   logic                    v1_ff, v1_in;
   logic        [COLZ_W-1:0] colz1_ff, colz1_in;
   logic        [COLZ_W-1:0] rowz1_ff, rowz1_in;
   logic        [CEN_W-1:0]  cenx1_ff, cenx1_in;
   logic        [CEN_W-1:0]  ceny1_ff, ceny1_in;
   logic signed [HGT_W-1:0]  hgt1_ff, hgt1_in;
   logic        [HDIV_W-1:0] rem1_ff, rem1_in;
   logic        [ZOOM_W-1:0] quo1_ff, quo1_in;

   // stage 2: centering, lower quotient bits
   logic                    v2_ff, v2_in;
   logic signed [OUT_W-1:0]  x2_ff, x2_in;
   logic signed [OUT_W-1:0]  y2_ff, y2_in;
   logic signed [HGT_W-1:0]  hgt2_ff, hgt2_in;
   logic        [ZOOM_W-1:0] hscale2_ff, hscale2_in;

   // stage 3: height scaling
   logic                    v3_ff, v3_in;
   logic signed [OUT_W-1:0]  x3_ff, x3_in;
   logic signed [OUT_W-1:0]  y3_ff, y3_in;
   logic signed [OUT_W-1:0]  z3_ff, z3_in;

   logic        [HDIV_W:0]   rem_a, rem_b;
   logic        [ZOOM_W-1:0] quo_b;
   logic signed [ZPROD_W-1:0] zprod;

   always_comb begin
      v1_in    = in_valid;
      colz1_in = grid_col * cfg.zoom;
      rowz1_in = grid_row * cfg.zoom;
      cenx1_in = cfg.map_columns * cfg.zoom;
      ceny1_in = cfg.map_rows * cfg.zoom;
      hgt1_in  = height;

      // restoring division zoom / height_divisor, upper half
      rem_a   = '0;
      quo1_in = '0;
      for (int i = ZOOM_W - 1; i >= DIV_SPLIT; i--) begin
         rem_a = {rem_a[HDIV_W-1:0], cfg.zoom[i]};
         if (rem_a >= {1'b0, cfg.height_divisor}) begin
            rem_a      = rem_a - {1'b0, cfg.height_divisor};
            quo1_in[i] = 1'b1;
         end
      end
      rem1_in = rem_a[HDIV_W-1:0];
   end

   always_comb begin
      v2_in   = v1_ff;
      x2_in   = OUT_W'(colz1_ff) - OUT_W'(cenx1_ff >> 1);
      y2_in   = OUT_W'(rowz1_ff) - OUT_W'(ceny1_ff >> 1);
      hgt2_in = hgt1_ff;

      // lower half of the division
      rem_b = {1'b0, rem1_ff};
      quo_b = quo1_ff;
      for (int i = DIV_SPLIT - 1; i >= 0; i--) begin
         rem_b = {rem_b[HDIV_W-1:0], cfg.zoom[i]};
         if (rem_b >= {1'b0, cfg.height_divisor}) begin
            rem_b    = rem_b - {1'b0, cfg.height_divisor};
            quo_b[i] = 1'b1;
         end
      end
      // zero divisor gives zero height scale
      hscale2_in = (cfg.height_divisor == '0) ? '0 : quo_b;
   end

   always_comb begin
      v3_in = v2_ff;
      x3_in = x2_ff;
      y3_in = y2_ff;
      zprod = hgt2_ff * $signed({1'b0, hscale2_ff});
      z3_in = OUT_W'(zprod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      colz1_ff   <= colz1_in;
      rowz1_ff   <= rowz1_in;
      cenx1_ff   <= cenx1_in;
      ceny1_ff   <= ceny1_in;
      hgt1_ff    <= hgt1_in;
      rem1_ff    <= rem1_in;
      quo1_ff    <= quo1_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      hgt2_ff    <= hgt2_in;
      hscale2_ff <= hscale2_in;
      x3_ff      <= x3_in;
      y3_ff      <= y3_in;
      z3_ff      <= z3_in;
   end

   assign out_valid = v3_ff;
   assign out_pt    = '{x: x3_ff, y: y3_ff, z: z3_ff};

endmodule

`default_nettype wire

// File: src/wip_rot.sv
`default_nettype none

// a' = a*c + b*s ; b' = b*c - a*s ; p rides along
module wip_rot #(
   parameter int FRAC_BITS = wip_pkg::FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [wip_pkg::OUT_W-1:0]  in_a,
   input  logic signed [wip_pkg::OUT_W-1:0]  in_b,
   input  logic signed [wip_pkg::OUT_W-1:0]  in_p,
   input  logic signed [wip_pkg::COEF_W-1:0] cos_c,
   input  logic signed [wip_pkg::COEF_W-1:0] sin_c,
   output logic                              out_valid,
   output logic signed [wip_pkg::OUT_W-1:0]  out_a,
   output logic signed [wip_pkg::OUT_W-1:0]  out_b,
   output logic signed [wip_pkg::OUT_W-1:0]  out_p
);
   import wip_pkg::*;

   // stage A: products
   logic                     va_ff, va_in;
   logic signed [PROD_W-1:0] pac_ff, pac_in;
   logic signed [PROD_W-1:0] pbs_ff, pbs_in;
   logic signed [PROD_W-1:0] pas_ff, pas_in;
   logic signed [PROD_W-1:0] pbc_ff, pbc_in;
   logic signed [OUT_W-1:0]  pa_ff, pa_in;

   // stage B: sums
   logic                     vb_ff, vb_in;
   logic signed [SUM_W-1:0]  suma_ff, suma_in;
   logic signed [SUM_W-1:0]  sumb_ff, sumb_in;
   logic signed [OUT_W-1:0]  pb_ff, pb_in;

   // stage C: truncate toward zero
   logic                     vc_ff, vc_in;
   logic signed [OUT_W-1:0]  ra_ff, ra_in;
   logic signed [OUT_W-1:0]  rb_ff, rb_in;
   logic signed [OUT_W-1:0]  pc_ff, pc_in;

   always_comb begin
      va_in   = in_valid;
      pac_in  = in_a * cos_c;
      pbs_in  = in_b * sin_c;
      pas_in  = in_a * sin_c;
      pbc_in  = in_b * cos_c;
      pa_in   = in_p;

      vb_in   = va_ff;
      suma_in = SUM_W'(pac_ff) + SUM_W'(pbs_ff);
      sumb_in = SUM_W'(pbc_ff) - SUM_W'(pas_ff);
      pb_in   = pa_ff;

      vc_in   = vb_ff;
      ra_in   = trunc_frac(WIDE_W'(suma_ff), FRAC_BITS);
      rb_in   = trunc_frac(WIDE_W'(sumb_ff), FRAC_BITS);
      pc_in   = pb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vc_ff <= vc_in;
      end
   end

   always_ff @(posedge clock) begin
      pac_ff  <= pac_in;
      pbs_ff  <= pbs_in;
      pas_ff  <= pas_in;
      pbc_ff  <= pbc_in;
      pa_ff   <= pa_in;
      suma_ff <= suma_in;
      sumb_ff <= sumb_in;
      pb_ff   <= pb_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      pc_ff   <= pc_in;
   end

   assign out_valid = vc_ff;
   assign out_a     = ra_ff;
   assign out_b     = rb_ff;
   assign out_p     = pc_ff;

endmodule

`default_nettype wire

// File: src/wip_iso.sv
`default_nettype none

module wip_iso #(
   parameter int SCREEN_W = wip_pkg::SCREEN_W,
   parameter int SCREEN_H = wip_pkg::SCREEN_H
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  wip_pkg::point_type               in_pt,
   input  wip_pkg::cfg_type                 cfg,
   output logic                             out_valid,
   output logic signed [wip_pkg::OUT_W-1:0] screen_x,
   output logic signed [wip_pkg::OUT_W-1:0] screen_y,
   output logic signed [wip_pkg::OUT_W-1:0] depth
);
   import wip_pkg::*;

   localparam logic signed [ISO_COEF_W-1:0] COS30 = ISO_COEF_W'(ISO_COS30);

   logic                     v1_ff, v1_in;
   logic signed [OUT_W-1:0]  d1_ff, d1_in;
   logic signed [OUT_W-1:0]  s1_ff, s1_in;
   logic signed [OUT_W-1:0]  z1_ff, z1_in;

   logic                     v2_ff, v2_in;
   logic signed [ISO_W-1:0]  p2_ff, p2_in;
   logic signed [ISO_W-1:0]  q2_ff, q2_in;
   logic signed [OUT_W-1:0]  z2_ff, z2_in;

   logic                     v3_ff, v3_in;
   logic signed [OUT_W-1:0]  nx3_ff, nx3_in;
   logic signed [OUT_W-1:0]  ny3_ff, ny3_in;
   logic signed [OUT_W-1:0]  z3_ff, z3_in;

   logic                     v4_ff, v4_in;
   logic signed [OUT_W-1:0]  sx4_ff, sx4_in;
   logic signed [OUT_W-1:0]  sy4_ff, sy4_in;
   logic signed [OUT_W-1:0]  z4_ff, z4_in;

   always_comb begin
      v1_in  = in_valid;
      d1_in  = in_pt.x - in_pt.y;
      s1_in  = in_pt.x + in_pt.y;
      z1_in  = in_pt.z;

      // sin 30 is a power of two: shift, no multiplier
      v2_in  = v1_ff;
      p2_in  = d1_ff * COS30;
      q2_in  = (ISO_W'(s1_ff) <<< ISO_SIN30_SH) - (ISO_W'(z1_ff) <<< ISO_FRAC);
      z2_in  = z1_ff;

      v3_in  = v2_ff;
      nx3_in = trunc_frac(WIDE_W'(p2_ff), ISO_FRAC);
      ny3_in = trunc_frac(WIDE_W'(q2_ff), ISO_FRAC);
      z3_in  = z2_ff;

      v4_in  = v3_ff;
      sx4_in = nx3_ff + OUT_W'(SCREEN_W / 2) + OUT_W'(cfg.offset_x);
      sy4_in = ny3_ff + OUT_W'(SCREEN_H / 2) + OUT_W'(cfg.offset_y);
      z4_in  = z3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff  <= d1_in;
      s1_ff  <= s1_in;
      z1_ff  <= z1_in;
      p2_ff  <= p2_in;
      q2_ff  <= q2_in;
      z2_ff  <= z2_in;
      nx3_ff <= nx3_in;
      ny3_ff <= ny3_in;
      z3_ff  <= z3_in;
      sx4_ff <= sx4_in;
      sy4_ff <= sy4_in;
      z4_ff  <= z4_in;
   end

   assign out_valid = v4_ff;
   assign screen_x  = sx4_ff;
   assign screen_y  = sy4_ff;
   assign depth     = z4_ff;

endmodule

`default_nettype wire

// File: src/wireframe_isometric_projection_core.sv
`default_nettype none

// Isometric wireframe projection: one height-map vertex in, one screen point out.
//
// Request: start with req_grid_col, req_grid_row, req_height. A request transfer
// happens at a rising edge with start high and busy low. busy is high only while
// in reset and for the first cycle after it; otherwise a request can be taken
// every cycle.
// Result: rsp_strobe marks one cycle holding rsp_screen_x, rsp_screen_y and
// rsp_depth_out. Results transfer in request order. The receiver has no way to
// stall; results are never held.
// Throughput: one vertex per cycle. The pipeline has 3 stages of scaling/centering
// (the zoom / height_divisor quotient is built in the first two, 5 bits each),
// 3 stages per rotation for X, Y and Z, and 4 stages of isometric step and
// screen offset.
// Control registers: csr_write_en, csr_index, csr_wdata write one register per
// cycle, no wait state. Write only while no vertex is in flight.
// Reset: synchronous; clears all valid bits and loads the register defaults
// (zoom 1, divisor 1, map 1x1, offsets 0, cos 1.0, sin 0).
module wireframe_isometric_projection_core #(
   parameter int SCREEN_W  = wip_pkg::SCREEN_W,
   parameter int SCREEN_H  = wip_pkg::SCREEN_H,
   parameter int FRAC_BITS = wip_pkg::FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic        [wip_pkg::COL_W-1:0]      req_grid_col,
   input  logic        [wip_pkg::COL_W-1:0]      req_grid_row,
   input  logic signed [wip_pkg::HGT_W-1:0]      req_height,
   input  logic                                  csr_write_en,
   input  logic        [wip_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [wip_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                                  rsp_strobe,
   output logic signed [wip_pkg::OUT_W-1:0]      rsp_screen_x,
   output logic signed [wip_pkg::OUT_W-1:0]      rsp_screen_y,
   output logic signed [wip_pkg::OUT_W-1:0]      rsp_depth_out
);
   import wip_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      busy_ff;
   logic      accept;

   logic      front_valid;
   point_type front_pt;

   logic                    rx_valid;
   logic signed [OUT_W-1:0] rx_y, rx_z, rx_x;
   logic                    ry_valid;
   logic signed [OUT_W-1:0] ry_x, ry_z, ry_y;
   logic                    rz_valid;
   logic signed [OUT_W-1:0] rz_y, rz_x, rz_z;

   point_type rot_pt;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   // register writes; out-of-range bits of the data word are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ZOOM:        cfg_in.zoom           = csr_wdata[ZOOM_W-1:0];
            CSR_HEIGHT_DIV:  cfg_in.height_divisor = csr_wdata[HDIV_W-1:0];
            CSR_MAP_COLUMNS: cfg_in.map_columns    = csr_wdata[MAP_W-1:0];
            CSR_MAP_ROWS:    cfg_in.map_rows       = csr_wdata[MAP_W-1:0];
            CSR_OFFSET_X:    cfg_in.offset_x       = $signed(csr_wdata[OFS_W-1:0]);
            CSR_OFFSET_Y:    cfg_in.offset_y       = $signed(csr_wdata[OFS_W-1:0]);
            CSR_COS_ANGLE:   cfg_in.cos_angle      = $signed(csr_wdata[COEF_W-1:0]);
            CSR_SIN_ANGLE:   cfg_in.sin_angle      = $signed(csr_wdata[COEF_W-1:0]);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= CFG_RESET;
         busy_ff <= 1'b1;
      end else begin
         cfg_ff  <= cfg_in;
         busy_ff <= 1'b0;
      end
   end

   // scale, center, height scale
   wip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .grid_col  (req_grid_col),
      .grid_row  (req_grid_row),
      .height    (req_height),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_pt    (front_pt)
   );

   // about X: (y, z) rotate, x rides along
   wip_rot #(
      .FRAC_BITS (FRAC_BITS)
   ) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_a      (front_pt.y),
      .in_b      (front_pt.z),
      .in_p      (front_pt.x),
      .cos_c     (cfg_ff.cos_angle),
      .sin_c     (cfg_ff.sin_angle),
      .out_valid (rx_valid),
      .out_a     (rx_y),
      .out_b     (rx_z),
      .out_p     (rx_x)
   );

   // about Y: (x, z) rotate, y rides along
   wip_rot #(
      .FRAC_BITS (FRAC_BITS)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rx_valid),
      .in_a      (rx_x),
      .in_b      (rx_z),
      .in_p      (rx_y),
      .cos_c     (cfg_ff.cos_angle),
      .sin_c     (cfg_ff.sin_angle),
      .out_valid (ry_valid),
      .out_a     (ry_x),
      .out_b     (ry_z),
      .out_p     (ry_y)
   );

   // about Z: x' = x*c - y*s, y' = x*s + y*c, i.e. the same pair form with a = y, b = x
   wip_rot #(
      .FRAC_BITS (FRAC_BITS)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ry_valid),
      .in_a      (ry_y),
      .in_b      (ry_x),
      .in_p      (ry_z),
      .cos_c     (cfg_ff.cos_angle),
      .sin_c     (cfg_ff.sin_angle),
      .out_valid (rz_valid),
      .out_a     (rz_y),
      .out_b     (rz_x),
      .out_p     (rz_z)
   );

   assign rot_pt = '{x: rz_x, y: rz_y, z: rz_z};

   // isometric step, screen center and offsets; last stage is the output register
   wip_iso #(
      .SCREEN_W  (SCREEN_W),
      .SCREEN_H  (SCREEN_H)
   ) u_iso (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rz_valid),
      .in_pt     (rot_pt),
      .cfg       (cfg_ff),
      .out_valid (rsp_strobe),
      .screen_x  (rsp_screen_x),
      .screen_y  (rsp_screen_y),
      .depth     (rsp_depth_out)
   );

`ifndef SYNTHESIS
   // every result strobe traces back to an accepted request
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT))
      else $error("result strobe without matching request");

   // front section valid traces back to an accepted request
   assert property (@(posedge clock) disable iff (reset)
      front_valid |-> $past(accept, FRONT_LAT))
      else $error("front section valid out of step");

   // a zoom write lands in the register on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && csr_index == CSR_ZOOM) |=>
         cfg_ff.zoom == $past(csr_wdata[ZOOM_W-1:0]))
      else $error("zoom register write lost");

   // busy drops once reset is released
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> !busy)
      else $error("busy held outside reset");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import wip_pkg::*;

   // One projected screen point: the three result fields of one transfer.
   typedef struct packed {
      int sx;
      int sy;
      int depth;
   } screen_point_t;

   // Directed stimulus is a list of steps: a register write or a vertex.
   typedef enum logic {
      STEP_VERTEX,
      STEP_CSR
   } step_kind_e;

   typedef struct packed {
      step_kind_e                kind;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_DATA_W-1:0]     wdata;
      logic [COL_W-1:0]          col;
      logic [COL_W-1:0]          row;
      logic signed [HGT_W-1:0]   h;
      bit                        typed_in;  // expected point given below, else predicted
      screen_point_t             want;
   } plan_row_t;

   localparam int PHASE_COUNT     = 8;
   localparam int VERTS_PER_PHASE = 235;
   localparam int MAX_GRID        = (1 << COL_W) - 1;

   // Directed part. Rows with typed_in set are worked out by hand; at reset
   // values (zoom 1, 1x1 map, identity rotation) a vertex maps to
   // x = trunc((col - row) * cos30) + 960, y = trunc((col + row) / 2 - h) + 540.
   localparam plan_row_t DIRECTED_PLAN [37] = '{
      // reset configuration: corners, height extremes, truncation toward zero
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd0,    16'sd0,   1'b1, '{960, 540, 0}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd0,    16'sd100, 1'b1, '{960, 440, 100}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd4095, 12'd0,    16'sd0,   1'b1, '{4506, 2587, 0}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd4095, 16'sd0,   1'b1, '{-2586, 2587, 0}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd1,    12'd0,    16'sd0,   1'b1, '{960, 540, 0}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd1,    16'sd0,   1'b1, '{960, 540, 0}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd2,    16'sd0,   1'b1, '{959, 541, 0}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd0,    16'h8000, 1'b1, '{960, 33308, -32768}},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd4095, 12'd4095, 16'h7FFF, 1'b1, '{960, -28132, 32767}},
      // screen offsets at their extremes
      '{STEP_CSR, CSR_OFFSET_X, 16'h8000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_OFFSET_Y, 16'h7FFF, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0, 12'd0, 16'sd0, 1'b1, '{-31808, 33307, 0}},
      // full zoom (junk above the field), zero height divisor, largest map, cos -1.0 and sin 1.0
      '{STEP_CSR, CSR_ZOOM,        16'hFFFF, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_HEIGHT_DIV,  16'h0000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_MAP_COLUMNS, 16'h1000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_MAP_ROWS,    16'h1000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_COS_ANGLE,   16'hC000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_SIN_ANGLE,   16'h4000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd4095, 12'd4095, 16'h8000, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd0,    16'h7FFF, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd2048, 12'd1,    16'hFFFF, 1'b0, '0},
      // largest divisor, widest map field, coefficients past +/-1.0
      '{STEP_CSR, CSR_HEIGHT_DIV,  16'h00FF, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_MAP_COLUMNS, 16'h1FFF, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_MAP_ROWS,    16'h0001, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_COS_ANGLE,   16'h7FFF, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_SIN_ANGLE,   16'h8000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd4095, 12'd0,    16'h7FFF, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd4095, 16'h8000, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd1234, 12'd3000, 16'hFFFF, 1'b0, '0},
      // zero zoom collapses everything onto the screen center plus offsets
      '{STEP_CSR, CSR_ZOOM,       16'h0000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_HEIGHT_DIV, 16'hFF01, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd4095, 12'd4095, 16'h7FFF, 1'b1, '{-31808, 33307, 0}},
      // quarter turn, pure sine
      '{STEP_CSR, CSR_ZOOM,      16'h03FF, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_COS_ANGLE, 16'h0000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_CSR, CSR_SIN_ANGLE, 16'h4000, 12'd0, 12'd0, 16'sd0, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd4095, 12'd4095, 16'h7FFF, 1'b0, '0},
      '{STEP_VERTEX, CSR_ZOOM, 16'h0, 12'd0,    12'd0,    16'h8000, 1'b0, '0}
   };

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [COL_W-1:0]        req_grid_col;
   logic [COL_W-1:0]        req_grid_row;
   logic signed [HGT_W-1:0] req_height;
   logic                    csr_write_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    rsp_strobe;
   logic signed [OUT_W-1:0] rsp_screen_x;
   logic signed [OUT_W-1:0] rsp_screen_y;
   logic signed [OUT_W-1:0] rsp_depth_out;

   // Shadow of the register file, updated as each write is issued.
   cfg_type       active_regs = CFG_RESET;
   // Points still due from the pipeline, oldest first.
   screen_point_t expected_points [$];
   int            mismatch_count  = 0;
   int            sender_idle_pct = 0;

   wireframe_isometric_projection_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_grid_col  (req_grid_col),
      .req_grid_row  (req_grid_row),
      .req_height    (req_height),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_strobe    (rsp_strobe),
      .rsp_screen_x  (rsp_screen_x),
      .rsp_screen_y  (rsp_screen_y),
      .rsp_depth_out (rsp_depth_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Wrap to 32-bit two's complement.
   function automatic int to_word(input longint v);
      return int'(v);
   endfunction

   // Drop the fraction bits, rounding toward zero (not floor).
   function automatic int drop_frac(input longint v, input int sh);
      return to_word(v / (longint'(1) <<< sh));
   endfunction

   // a' = a*c + b*s ; b' = b*c - a*s
   function automatic void rotate_pair(inout int a, inout int b,
                                       input longint c, input longint s);
      int na;
      int nb;
      na = drop_frac(longint'(a) * c + longint'(b) * s, FRAC_BITS);
      nb = drop_frac(longint'(b) * c - longint'(a) * s, FRAC_BITS);
      a  = na;
      b  = nb;
   endfunction

   function automatic screen_point_t project_vertex(
      input logic [COL_W-1:0]        col,
      input logic [COL_W-1:0]        row,
      input logic signed [HGT_W-1:0] h,
      input cfg_type                 regs);
      longint        zoom_l;
      longint        hscale;
      longint        c;
      longint        s;
      longint        diff;
      longint        sum;
      int            x;
      int            y;
      int            z;
      int            nx;
      int            ny;
      screen_point_t pt;
      zoom_l = longint'(regs.zoom);
      hscale = (regs.height_divisor == 0) ? 0 : zoom_l / longint'(regs.height_divisor);
      // scale, then pull the map center to the origin
      x = to_word(longint'(col) * zoom_l - longint'(regs.map_columns) * zoom_l / 2);
      y = to_word(longint'(row) * zoom_l - longint'(regs.map_rows) * zoom_l / 2);
      z = to_word(longint'(h) * hscale);
      c = longint'(regs.cos_angle);
      s = longint'(regs.sin_angle);
      rotate_pair(y, z, c, s);   // about X
      rotate_pair(x, z, c, s);   // about Y
      rotate_pair(x, y, c, -s);  // about Z, opposite sense
      diff = longint'(to_word(longint'(x) - longint'(y)));
      sum  = longint'(to_word(longint'(x) + longint'(y)));
      nx   = drop_frac(diff * ISO_COS30, ISO_FRAC);
      ny   = drop_frac(sum * ISO_SIN30 - longint'(z) * (longint'(1) <<< ISO_FRAC), ISO_FRAC);
      pt.sx    = to_word(longint'(nx) + SCREEN_W / 2 + longint'(regs.offset_x));
      pt.sy    = to_word(longint'(ny) + SCREEN_H / 2 + longint'(regs.offset_y));
      pt.depth = z;
      return pt;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // mode 0: top of the nominal range, 1: bottom (top on a rare roll), otherwise
   // random with the occasional extreme, zero, or a raw 16-bit word (bits above the
   // register, coefficients beyond +/-1.0).
   function automatic logic [CSR_DATA_W-1:0] pick_register_value(
      input logic [CSR_IDX_W-1:0] idx,
      input int                   mode);
      int lo;
      int hi;
      int roll;
      lo = -16384;
      hi = 16384;
      case (idx)
         CSR_ZOOM: begin
            lo = 1;
            hi = 1023;
         end
         CSR_HEIGHT_DIV: begin
            lo = 1;
            hi = 255;
         end
         CSR_MAP_COLUMNS, CSR_MAP_ROWS: begin
            lo = 1;
            hi = 4096;
         end
         CSR_OFFSET_X, CSR_OFFSET_Y: begin
            lo = -32768;
            hi = 32767;
         end
         default: ;
      endcase
      roll = $urandom_range(19);
      if (mode == 0 || roll == 0)
         return CSR_DATA_W'(hi);
      else if (mode == 1 || roll == 1)
         return CSR_DATA_W'(lo);
      else if (roll == 2)
         return '0;
      else if (roll == 3)
         return CSR_DATA_W'($urandom());
      else
         return CSR_DATA_W'(lo + int'($urandom_range(hi - lo)));
   endfunction

   function automatic logic [COL_W-1:0] pick_grid();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0)
         return '0;
      else if (roll == 1)
         return COL_W'(MAX_GRID);
      else
         return COL_W'($urandom());
   endfunction

   // Drop start and wait until every issued vertex has come back.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   // Register writes only happen with the pipeline empty.
   task automatic apply_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] data);
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_ZOOM:        active_regs.zoom           = data[ZOOM_W-1:0];
         CSR_HEIGHT_DIV:  active_regs.height_divisor = data[HDIV_W-1:0];
         CSR_MAP_COLUMNS: active_regs.map_columns    = data[MAP_W-1:0];
         CSR_MAP_ROWS:    active_regs.map_rows       = data[MAP_W-1:0];
         CSR_OFFSET_X:    active_regs.offset_x       = data;
         CSR_OFFSET_Y:    active_regs.offset_y       = data;
         CSR_COS_ANGLE:   active_regs.cos_angle      = data;
         CSR_SIN_ANGLE:   active_regs.sin_angle      = data;
         default: ;
      endcase
   endtask

   // Offer one vertex, after a random idle gap, and hold it until the
   // transfer (start high, busy low at the edge). start is left high so
   // back-to-back vertices stream at full rate.
   task automatic issue_vertex(input logic [COL_W-1:0]        col,
                               input logic [COL_W-1:0]        row,
                               input logic signed [HGT_W-1:0] h,
                               input bit                      typed_in,
                               input screen_point_t           want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_grid_col <= col;
      req_grid_row <= row;
      req_height   <= h;
      do @(posedge clock); while (busy !== 1'b0);
      expected_points.push_back(typed_in ? want : project_vertex(col, row, h, active_regs));
   endtask

   // ---------------------------------------------------------------- checking

   // Results cannot be stalled: every strobe is a transfer, matched in order.
   always @(posedge clock) begin
      screen_point_t want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected transfer x=%0d y=%0d depth=%0d", $time,
                     rsp_screen_x, rsp_screen_y, rsp_depth_out);
            mismatch_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_screen_x !== want.sx) begin
               $display("%0t: screen_x expected %0d actual %0d", $time, want.sx, rsp_screen_x);
               mismatch_count++;
            end
            if (rsp_screen_y !== want.sy) begin
               $display("%0t: screen_y expected %0d actual %0d", $time, want.sy, rsp_screen_y);
               mismatch_count++;
            end
            if (rsp_depth_out !== want.depth) begin
               $display("%0t: depth_out expected %0d actual %0d", $time, want.depth,
                        rsp_depth_out);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      plan_row_t step;
      int        phase;
      int        k;
      start        <= 1'b0;
      req_grid_col <= '0;
      req_grid_row <= '0;
      req_height   <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_ZOOM;
      csr_wdata    <= '0;
      reset        <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling; busy covers the cycle after reset
      for (k = 0; k < $size(DIRECTED_PLAN); k++) begin
         step = DIRECTED_PLAN[k];
         if (step.kind == STEP_CSR)
            apply_register(step.idx, step.wdata);
         else
            issue_vertex(step.col, step.row, step.h, step.typed_in, step.want);
      end

      // random phases: fresh register set each phase (all-high first,
      // mostly-low second), sender idle pattern rotating through the phases
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         for (k = 0; k < 8; k++)
            apply_register(CSR_IDX_W'(k), pick_register_value(CSR_IDX_W'(k), phase));
         case (phase % 4)
            1:       sender_idle_pct = 75;
            3:       sender_idle_pct = 9;
            default: sender_idle_pct = 0;
         endcase
         repeat (VERTS_PER_PHASE)
            issue_vertex(pick_grid(), pick_grid(), HGT_W'($urandom()), 1'b0, '0);
      end

      // drain, then watch for stray strobes
      settle();
      repeat (PIPE_LAT + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog: well past the slowest legal run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
